// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/pdaf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdaf_pkg
// shared types and constants of the duplicate atom filter
// ----------------------------------------------------------------------------
package pdaf_pkg;
    localparam int MAX_ATOMS = 1024;
    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam int COORD_W = 20;
    localparam int BOX_W = 19;
    localparam int DIST_W = 16;
    localparam int POS_W = 3 * COORD_W;
    localparam int IDX_W = 10;

    localparam logic [1:0] REG_BOX_X = 2'd0;
    localparam logic [1:0] REG_BOX_Y = 2'd1;
    localparam logic [1:0] REG_BOX_Z = 2'd2;
    localparam logic [1:0] REG_MIN_DIST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, clear counts on start_set
        logic rd;         // issue store read at scan address
        logic finish;     // write store, update counts, load result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // address at stored count - 1 or empty
        logic pipe_busy;  // compare pipeline still holds reads
    } t_sts;
endpackage

// ===== rtl/periodic_duplicate_atom_filter.sv =====
// ----------------------------------------------------------------------------
// periodic_duplicate_atom_filter
// close pair removal of atom positions under a periodic box
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one atom request: tuser = start_set, tdata = x, y, z
//   (20 bit signed Q10.10 each). m_axis returns one result per request.
//   each atom is compared with every atom stored so far in its set, one
//   store entry per cycle through a three stage wrap/square/sum pipeline
//   fed by a single port store memory with registered read
//   a request is scanned against all n stored atoms (up to 1024), the
//   pipeline drains, then the result is loaded; an empty or restarted
//   set skips scan and drain; the next request is taken in the cycle its
//   predecessor's result is taken, and not before
//   the result stays in its register while m_axis_tready is low, and no
//   new request is taken until it is delivered
//   reset empties the set and loads box = 0, min_distance = 1024;
//   the store memory needs no clearing, only written entries are read
//   apb registers: 0x0 box_x, 0x4 box_y, 0x8 box_z, 0xc min_distance
// ----------------------------------------------------------------------------
module periodic_duplicate_atom_filter import pdaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // atom_x, atom_y, atom_z, zero fill
    input  logic        s_axis_tuser,   // start_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // atom_index, is_duplicate, kept_index, set_full
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [BOX_W-1:0]  r_box_x, r_box_y, r_box_z;
    logic [DIST_W-1:0] r_min_dist;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [IDX_W-1:0] w_idx, w_kept;
    logic w_dup, w_full, w_empty, w_dp_empty;

    // configuration registers, written on the access phase
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x    <= '0;
            r_box_y    <= '0;
            r_box_z    <= '0;
            r_min_dist <= DIST_W'(1024);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_BOX_X:    r_box_x    <= pwdata[BOX_W-1:0];
                REG_BOX_Y:    r_box_y    <= pwdata[BOX_W-1:0];
                REG_BOX_Z:    r_box_z    <= pwdata[BOX_W-1:0];
                REG_MIN_DIST: r_min_dist <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BOX_X:    prdata = {13'd0, r_box_x};
            REG_BOX_Y:    prdata = {13'd0, r_box_y};
            REG_BOX_Z:    prdata = {13'd0, r_box_z};
            REG_MIN_DIST: prdata = {16'd0, r_min_dist};
            default:      prdata = '0;
        endcase
    end

    // nothing to scan when the set is empty or restarted by this request
    assign w_empty = s_axis_tuser || w_dp_empty;

    pdaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_empty_scan(w_empty),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    pdaf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_start_set   (s_axis_tuser),
        .i_atom_x      (s_axis_tdata[19:0]),
        .i_atom_y      (s_axis_tdata[39:20]),
        .i_atom_z      (s_axis_tdata[59:40]),
        .i_box_x       (r_box_x),
        .i_box_y       (r_box_y),
        .i_box_z       (r_box_z),
        .i_min_dist    (r_min_dist),
        .o_atom_index  (w_idx),
        .o_is_duplicate(w_dup),
        .o_kept_index  (w_kept),
        .o_set_full    (w_full),
        .o_empty       (w_dp_empty)
    );

    assign m_axis_tdata = {2'b00, w_full, w_kept, w_dup, w_idx};
endmodule

// ===== rtl/pdaf_ram.sv =====
// ----------------------------------------------------------------------------
// pdaf_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module pdaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pdaf_datapath.sv =====
// ----------------------------------------------------------------------------
// pdaf_datapath
// position store, wrap and distance pipeline, counters and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pdaf_datapath import pdaf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_start_set,
    input  logic [COORD_W-1:0]  i_atom_x,
    input  logic [COORD_W-1:0]  i_atom_y,
    input  logic [COORD_W-1:0]  i_atom_z,
    input  logic [BOX_W-1:0]    i_box_x,
    input  logic [BOX_W-1:0]    i_box_y,
    input  logic [BOX_W-1:0]    i_box_z,
    input  logic [DIST_W-1:0]   i_min_dist,
    output logic [IDX_W-1:0]    o_atom_index,
    output logic                o_is_duplicate,
    output logic [IDX_W-1:0]    o_kept_index,
    output logic                o_set_full,
    output logic                o_empty
);
    logic [POS_W-1:0]   r_atom;
    logic [CW-1:0]      r_stored, n_stored;
    logic [CW-1:0]      r_kept, n_kept;
    logic [CW-1:0]      r_addr;
    logic               r_dup;
    logic [2:0]         r_vld;
    logic [POS_W-1:0]   w_rdata;
    logic               w_full;
    logic [2*DIST_W-1:0] r_limit;
    logic [21:0]        r_d [3];
    logic [41:0]        r_sq [3];
    logic [43:0]        w_sum;
    logic [IDX_W-1:0]   r_o_idx, r_o_kept;
    logic               r_o_dup, r_o_full;
    logic               w_we;
    logic [AW-1:0]      w_ram_addr;
    logic [BOX_W-1:0]   w_box [3];

    assign w_full = (r_stored >= CW'(MAX_ATOMS));
    assign w_we   = i_cmd.finish && !w_full;
    assign w_ram_addr = i_cmd.finish ? r_stored[AW-1:0] : r_addr[AW-1:0];
    assign w_box[0] = i_box_x;
    assign w_box[1] = i_box_y;
    assign w_box[2] = i_box_z;

    pdaf_ram #(.WIDTH(POS_W), .DEPTH(MAX_ATOMS)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_ram_addr),
        .i_wdata(r_atom),
        .o_rdata(w_rdata)
    );

    assign o_sts.scan_last = (r_addr + CW'(1) >= r_stored);
    assign o_sts.pipe_busy = |r_vld;
    assign o_empty         = (r_stored == '0);

    // counts and scan address
    always_comb begin
        n_stored = r_stored;
        n_kept   = r_kept;
        if (i_cmd.load && i_start_set) begin
            n_stored = '0;
            n_kept   = '0;
        end else if (w_we) begin
            n_stored = r_stored + CW'(1);
            if (!r_dup) begin
                n_kept = r_kept + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= '0;
            r_kept   <= '0;
            r_addr   <= '0;
            r_vld    <= '0;
            r_dup    <= 1'b0;
        end else begin
            r_stored <= n_stored;
            r_kept   <= n_kept;
            r_vld    <= {r_vld[1:0], i_cmd.rd};
            if (i_cmd.load) begin
                r_addr <= '0;
                r_dup  <= 1'b0;
            end else begin
                if (i_cmd.rd) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (r_vld[2] && ({2'b00, w_sum} < {14'd0, r_limit})) begin
                    r_dup <= 1'b1;
                end
            end
        end
    end

    // stage 1: difference and wrap; stage 2: square; stage 3: sum and compare
    always_ff @(posedge i_clk) begin
        logic signed [21:0] d;
        logic signed [22:0] b;
        if (i_cmd.load) begin
            r_atom  <= {i_atom_z, i_atom_y, i_atom_x};
            r_limit <= i_min_dist * i_min_dist;
        end
        for (int a = 0; a < 3; a++) begin
            d = 22'(signed'(r_atom[a*COORD_W +: COORD_W]))
              - 22'(signed'(w_rdata[a*COORD_W +: COORD_W]));
            b = 23'(signed'({1'b0, w_box[a]}));
            if (23'(signed'({d, 1'b0})) > b) begin
                d = d - 22'(b);
            end
            if (23'(signed'({d, 1'b0})) < -b) begin
                d = d + 22'(b);
            end
            r_d[a]  <= d;
            r_sq[a] <= 42'($signed(r_d[a]) * $signed(r_d[a]));
        end
    end

    assign w_sum = 44'(r_sq[0]) + 44'(r_sq[1]) + 44'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_idx  <= (r_stored > CW'(1023)) ? IDX_W'(1023) : IDX_W'(r_stored);
            r_o_dup  <= r_dup;
            r_o_full <= w_full;
            r_o_kept <= (w_full || r_dup) ? '0 :
                        ((r_kept > CW'(1023)) ? IDX_W'(1023) : IDX_W'(r_kept));
        end
    end

    assign o_atom_index   = r_o_idx;
    assign o_is_duplicate = r_o_dup;
    assign o_kept_index   = r_o_kept;
    assign o_set_full     = r_o_full;

    `ASSERT_CLK(a_kept_le_stored, i_clk, i_rst_n, r_kept <= r_stored)
    `ASSERT_CLK(a_stored_bound, i_clk, i_rst_n, r_stored <= CW'(MAX_ATOMS))
    `ASSERT_CLK(a_no_rd_on_finish, i_clk, i_rst_n, !(i_cmd.rd && i_cmd.finish))
endmodule

// ===== rtl/pdaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdaf_ctrl
// controller that sequences accept, scan, drain and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pdaf_ctrl import pdaf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_empty_scan,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_empty_scan ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = i_empty_scan ? ST_DONE : ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `ASSERT_CLK(a_finish_then_out, i_clk, i_rst_n, o_cmd.finish |=> r_state == ST_OUT)
    `ASSERT_CLK(a_load_only_ready, i_clk, i_rst_n, o_cmd.load |-> o_in_ready)
endmodule

// ===== test/pdaf_checker.sv =====
// ----------------------------------------------------------------------------
// pdaf_checker
// watches both streams of the duplicate atom filter, predicts each result
// from its own copy of the atom store and box setup, and compares
// ----------------------------------------------------------------------------
module pdaf_checker import pdaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              full;
        logic [IDX_W-1:0]  kept;
        logic              dup;
        logic [IDX_W-1:0]  idx;
    } t_result;

    logic signed [COORD_W-1:0] atom_x [MAX_ATOMS];
    logic signed [COORD_W-1:0] atom_y [MAX_ATOMS];
    logic signed [COORD_W-1:0] atom_z [MAX_ATOMS];
    int unsigned n_stored, n_kept;
    logic [BOX_W-1:0]  box_x, box_y, box_z;
    logic [DIST_W-1:0] min_dist;
    t_result expected_results[$];

    assign o_pending = expected_results.size();

    function automatic longint wrap_diff(longint d, longint box);
        if (2 * d > box) d -= box;
        if (2 * d < -box) d += box;
        return d;
    endfunction

    task automatic report(string what, t_result got, t_result exp);
        $display("%0t: %s got %h expected %h", $realtime, what, got, exp);
        o_errors++;
    endtask

    function automatic t_result screen_atom(logic start, logic [63:0] data);
        t_result r;
        longint dx, dy, dz, x, y, z, lim;
        x = longint'($signed(data[19:0]));
        y = longint'($signed(data[39:20]));
        z = longint'($signed(data[59:40]));
        lim = longint'(min_dist) * longint'(min_dist);
        r = '0;
        if (start) begin
            n_stored = 0;
            n_kept = 0;
        end
        for (int i = 0; i < n_stored; i++) begin
            dx = wrap_diff(x - atom_x[i], box_x);
            dy = wrap_diff(y - atom_y[i], box_y);
            dz = wrap_diff(z - atom_z[i], box_z);
            if (dx * dx + dy * dy + dz * dz < lim) r.dup = 1'b1;
        end
        r.full = n_stored >= MAX_ATOMS;
        r.idx = n_stored > 1023 ? 10'd1023 : n_stored[IDX_W-1:0];
        if (!r.full) begin
            atom_x[n_stored] = data[19:0];
            atom_y[n_stored] = data[39:20];
            atom_z[n_stored] = data[59:40];
            n_stored++;
            if (!r.dup) begin
                r.kept = n_kept > 1023 ? 10'd1023 : n_kept[IDX_W-1:0];
                n_kept++;
            end
        end
        return r;
    endfunction

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_result got, exp;
        if (!i_rst_n) begin
            n_stored = 0;
            n_kept = 0;
            box_x = '0;
            box_y = '0;
            box_z = '0;
            min_dist = 16'd1024;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_BOX_X: box_x = pwdata[BOX_W-1:0];
                    REG_BOX_Y: box_y = pwdata[BOX_W-1:0];
                    REG_BOX_Z: box_z = pwdata[BOX_W-1:0];
                    REG_MIN_DIST: min_dist = pwdata[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(screen_atom(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[21:0];
                if (expected_results.size() == 0) begin
                    report("unexpected result", got, '0);
                end else begin
                    exp = expected_results.pop_front();
                    if (got.idx != exp.idx) report("atom_index", got, exp);
                    if (got.dup != exp.dup) report("is_duplicate", got, exp);
                    if (got.kept != exp.kept) report("kept_index", got, exp);
                    if (got.full != exp.full) report("set_full", got, exp);
                end
            end
        end
    end
endmodule

// ===== test/tb_periodic_duplicate_atom_filter.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_duplicate_atom_filter
// drives atom requests and box setups into the filter, with random gaps
// on both streams; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_periodic_duplicate_atom_filter import pdaf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;     // atom_x, atom_y, atom_z, zero fill
    logic        s_axis_tuser = 1'b0;   // start_set
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // atom_index, is_duplicate, kept_index, set_full
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    bit          calm;              // no idling on either side while set

    always #5 i_clk = ~i_clk;

    periodic_duplicate_atom_filter dut (.*);

    pdaf_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls about one cycle in ten unless calm
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 10);
    end

    // apb write: setup cycle then access cycle
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one atom request, held until accepted; random gap before it
    task automatic send_atom(logic start, logic [19:0] x, logic [19:0] y, logic [19:0] z);
        while (!calm && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= start;
        s_axis_tdata <= {4'b0, z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [19:0] near(logic [19:0] c, int spread);
        return c + 20'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic setup(logic [18:0] bx, logic [18:0] by, logic [18:0] bz, logic [15:0] md);
        write_reg(REG_BOX_X, {13'($urandom_range(8191)), bx});
        write_reg(REG_BOX_Y, {13'd0, by});
        write_reg(REG_BOX_Z, {13'd0, bz});
        write_reg(REG_MIN_DIST, {16'hffff, md});
    endtask

    initial begin
        logic [19:0] cx, cy, cz;
        int set_len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset setup, extremes of coordinates, exact threshold
        send_atom(1'b1, 20'h00000, 20'h00000, 20'h00000);
        send_atom(1'b0, 20'd1024, 20'h00000, 20'h00000);   // exactly at limit, kept
        send_atom(1'b0, 20'd1023, 20'h00000, 20'h00000);   // just inside, duplicate
        send_atom(1'b0, 20'h7ffff, 20'h80000, 20'h7ffff);
        send_atom(1'b0, 20'h80000, 20'h7ffff, 20'h80000);
        send_atom(1'b0, 20'h80000, 20'h7ffff, 20'h80000);  // same point again
        send_atom(1'b1, 20'h12345, 20'hfffff, 20'h00001);  // empty set, kept
        drain();

        // largest boxes and threshold, wrap across the box edge
        setup(19'h7ffff, 19'h7ffff, 19'h7ffff, 16'hffff);
        send_atom(1'b1, 20'h80000, 20'h80000, 20'h80000);
        send_atom(1'b0, 20'h7ffff, 20'h7ffff, 20'h7ffff);
        send_atom(1'b0, 20'h3ffff, 20'h00000, 20'hc0000);
        send_atom(1'b0, 20'h40000, 20'h40000, 20'h40000);
        drain();
        setup(19'd4096, 19'd4096, 19'd4096, 16'd0);        // nothing can be close
        send_atom(1'b1, 20'd100, 20'd100, 20'd100);
        send_atom(1'b0, 20'd100, 20'd100, 20'd100);
        send_atom(1'b0, 20'd2148, 20'd4196, 20'hff000);
        drain();
        setup(19'd4096, 19'd3000, 19'd1, 16'd600);
        send_atom(1'b1, 20'd10, 20'd10, 20'd10);
        send_atom(1'b0, 20'd4100, 20'd2900, 20'd10);      // wraps to a close image
        send_atom(1'b0, 20'hfff00, 20'd1500, 20'd11);
        drain();

        // random: short sets of atoms clustered near each other
        for (int n = 0; n < 560; ) begin
            if ($urandom_range(3) == 0) begin
                drain();
                setup($urandom_range(3) == 0 ? 19'($urandom) : 19'($urandom_range(20000)),
                      $urandom_range(3) == 0 ? 19'd0 : 19'($urandom_range(20000)),
                      19'($urandom),
                      $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3000)));
            end
            // long stretch with no idling in the middle of the run
            calm = (n >= 200 && n < 320) || $urandom_range(7) == 0;
            set_len = $urandom_range(1, 12);
            cx = 20'($urandom);
            cy = 20'($urandom);
            cz = 20'($urandom);
            for (int k = 0; k < set_len; k++, n++) begin
                if ($urandom_range(4) == 0)
                    send_atom($urandom_range(9) == 0, 20'($urandom), 20'($urandom), 20'($urandom));
                else
                    send_atom(k == 0, near(cx, 3000), near(cy, 3000), near(cz, 3000));
            end
        end
        calm = 1'b0;
        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
